### rtl/aae_pkg.sv
`default_nettype none

package aae_pkg;

    // Fixed-point layout of the datapath.
    localparam int GUARD_BITS = 8;
    localparam int ANG_FRAC   = 12;
    localparam int ANG_W      = 29;
    localparam int UNIT_W     = ANG_W - ANG_FRAC;
    localparam int TOL_W      = 8;
    localparam int GAIN_W     = 24;

    typedef logic signed [ANG_W-1:0]  angle_t;
    typedef logic signed [UNIT_W-1:0] units_t;
    typedef logic [TOL_W-1:0]         tol_t;

    localparam angle_t HALF_TURN_ACC = 29'sd94371840;
    localparam angle_t ROUND_HALF    = 29'sd2048;

    localparam units_t AZ_MAX = 17'sd23040;
    localparam units_t AZ_MIN = -17'sd23040;
    localparam units_t EL_MAX = 17'sd11520;
    localparam units_t EL_MIN = 17'sd0;

    // Reciprocal of the CORDIC gain, round(2^24 / 1.6467602581).
    localparam logic [GAIN_W-1:0] INV_GAIN_Q24 = 24'd10188014;

    // Rounded atan(2^-i) in 1/128 degree with twelve fraction bits.
    function automatic angle_t atan_entry(input int idx);
        angle_t val;
        begin
            case (idx)
                0:       val = 29'sd23592960;
                1:       val = 29'sd13927738;
                2:       val = 29'sd7359034;
                3:       val = 29'sd3735561;
                4:       val = 29'sd1875029;
                5:       val = 29'sd938429;
                6:       val = 29'sd469329;
                7:       val = 29'sd234679;
                8:       val = 29'sd117341;
                9:       val = 29'sd58671;
                10:      val = 29'sd29335;
                11:      val = 29'sd14668;
                12:      val = 29'sd7334;
                13:      val = 29'sd3667;
                14:      val = 29'sd1833;
                15:      val = 29'sd917;
                16:      val = 29'sd458;
                17:      val = 29'sd229;
                18:      val = 29'sd115;
                19:      val = 29'sd57;
                20:      val = 29'sd29;
                21:      val = 29'sd14;
                22:      val = 29'sd7;
                23:      val = 29'sd4;
                default: val = 29'sd0;
            endcase
            return val;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/aae_front.sv
`default_nettype none

module aae_front #(
    parameter int COORD_BITS = 32,
    parameter int W          = 44
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          en,
    input  wire aae_pkg::tol_t           tol,
    input  wire                          in_valid,
    input  wire signed [COORD_BITS-1:0]  mount_x,
    input  wire signed [COORD_BITS-1:0]  mount_y,
    input  wire signed [COORD_BITS-1:0]  mount_z,
    input  wire signed [COORD_BITS-1:0]  target_x,
    input  wire signed [COORD_BITS-1:0]  target_y,
    input  wire signed [COORD_BITS-1:0]  target_z,
    output logic                         out_valid,
    output logic signed [W-1:0]          x_out,
    output logic signed [W-1:0]          y_out,
    output aae_pkg::angle_t              z_out,
    output logic signed [W-1:0]          adz_out,
    output logic                         aim_out
);
    import aae_pkg::*;

    localparam int DW  = COORD_BITS + 1;
    localparam int EXT = W - DW - GUARD_BITS;

    logic                 v1_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [DW-1:0] dx_next, dy_next, dz_next;

    logic                 v2_reg;
    logic signed [W-1:0]  x_reg, y_reg, adz_reg;
    logic signed [W-1:0]  x_next, y_next, adz_next;
    angle_t               z_reg, z_next;
    logic                 aim_reg, aim_next;

    logic [DW-1:0]        mag_dx, mag_dy, mag_dz;
    logic signed [W-1:0]  x_scaled, y_scaled;

    // Differences are exact in one extra bit.
    assign dx_next = {target_x[COORD_BITS-1], target_x} - {mount_x[COORD_BITS-1], mount_x};
    assign dy_next = {target_y[COORD_BITS-1], target_y} - {mount_y[COORD_BITS-1], mount_y};
    assign dz_next = {target_z[COORD_BITS-1], target_z} - {mount_z[COORD_BITS-1], mount_z};

    always_comb
    begin
        mag_dx   = dx_reg[DW-1] ? (-dx_reg) : dx_reg;
        mag_dy   = dy_reg[DW-1] ? (-dy_reg) : dy_reg;
        mag_dz   = dz_reg[DW-1] ? (-dz_reg) : dz_reg;
        aim_next = !((mag_dx <= DW'(tol)) && (mag_dy <= DW'(tol)));
        x_scaled = {{EXT{dx_reg[DW-1]}}, dx_reg, {GUARD_BITS{1'b0}}};
        y_scaled = {{EXT{dy_reg[DW-1]}}, dy_reg, {GUARD_BITS{1'b0}}};
        adz_next = {{EXT{1'b0}}, mag_dz, {GUARD_BITS{1'b0}}};
        if (dx_reg[DW-1])
        begin
            // Turn the vector by half a turn so that the CORDIC sees x >= 0.
            x_next = -x_scaled;
            y_next = -y_scaled;
            z_next = dy_reg[DW-1] ? (-HALF_TURN_ACC) : HALF_TURN_ACC;
        end
        else
        begin
            x_next = x_scaled;
            y_next = y_scaled;
            z_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            dz_reg  <= dz_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            adz_reg <= adz_next;
            aim_reg <= aim_next;
        end
    end

    assign out_valid = v2_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign adz_out   = adz_reg;
    assign aim_out   = aim_reg;

endmodule

`default_nettype wire

### rtl/aae_cordic_cell.sv
`default_nettype none

module aae_cordic_cell #(
    parameter int W      = 44,
    parameter int STAGE  = 0,
    parameter int SIDE_W = 1
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   en,
    input  wire                   in_valid,
    input  wire signed [W-1:0]    x_in,
    input  wire signed [W-1:0]    y_in,
    input  wire aae_pkg::angle_t  z_in,
    input  wire [SIDE_W-1:0]      side_in,
    output logic                  out_valid,
    output logic signed [W-1:0]   x_out,
    output logic signed [W-1:0]   y_out,
    output aae_pkg::angle_t       z_out,
    output logic [SIDE_W-1:0]     side_out
);
    import aae_pkg::*;

    localparam angle_t ATAN_STEP = atan_entry(STAGE);

    logic                valid_reg;
    logic signed [W-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [W-1:0] x_shift, y_shift;
    angle_t              z_reg, z_next;
    logic [SIDE_W-1:0]   side_reg;

    // A residual of exactly zero takes the positive branch.
    always_comb
    begin
        x_shift = x_in >>> STAGE;
        y_shift = y_in >>> STAGE;
        if (!y_in[W-1])
        begin
            x_next = x_in + y_shift;
            y_next = y_in - x_shift;
            z_next = z_in + ATAN_STEP;
        end
        else
        begin
            x_next = x_in - y_shift;
            y_next = y_in + x_shift;
            z_next = z_in - ATAN_STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign side_out  = side_reg;

endmodule

`default_nettype wire

### rtl/aae_gain.sv
`default_nettype none

module aae_gain #(
    parameter int W      = 44,
    parameter int SIDE_W = 1
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  en,
    input  wire                  in_valid,
    input  wire signed [W-1:0]   x_in,
    input  wire signed [W-1:0]   adz_in,
    input  wire [SIDE_W-1:0]     side_in,
    output logic                 out_valid,
    output logic signed [W-1:0]  h_out,
    output logic signed [W-1:0]  adz_out,
    output logic [SIDE_W-1:0]    side_out
);
    import aae_pkg::*;

    localparam int HI_W = W - GAIN_W;
    localparam int LO_W = 2 * GAIN_W;

    logic                v1_reg, v2_reg;
    logic [W-1:0]        prod_hi_reg, prod_hi_next;
    logic [LO_W-1:0]     prod_lo_reg, prod_lo_next;
    logic signed [W-1:0] h_reg, h_next;
    logic signed [W-1:0] adz1_reg, adz2_reg;
    logic [SIDE_W-1:0]   side1_reg, side2_reg;

    // The length input is never negative, so the split into a high part and
    // a 24-bit low part needs no sign handling.
    assign prod_hi_next = {{GAIN_W{1'b0}}, x_in[W-1:GAIN_W]}
                        * {{HI_W{1'b0}}, INV_GAIN_Q24};
    assign prod_lo_next = {{GAIN_W{1'b0}}, x_in[GAIN_W-1:0]}
                        * {{GAIN_W{1'b0}}, INV_GAIN_Q24};
    assign h_next = prod_hi_reg + {{HI_W{1'b0}}, prod_lo_reg[LO_W-1:GAIN_W]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_hi_reg <= prod_hi_next;
            prod_lo_reg <= prod_lo_next;
            adz1_reg    <= adz_in;
            side1_reg   <= side_in;
            h_reg       <= h_next;
            adz2_reg    <= adz1_reg;
            side2_reg   <= side1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign h_out     = h_reg;
    assign adz_out   = adz2_reg;
    assign side_out  = side2_reg;

endmodule

`default_nettype wire

### rtl/aim_azimuth_elevation.sv
// Aiming unit: azimuth and elevation from a mount position to a target.
//
// Requests arrive on the input channel (in_valid / in_ready) as two signed
// coordinate triples; each request yields exactly one result on the output
// channel (out_valid / out_ready): aim_valid, azimuth and elevation, the
// angles in 1/128 degree. Results leave in request order.
// The block is a chain of CORDIC cells: two front stages form the difference
// vector and the tolerance test, CORDIC_STAGES cells find the azimuth, two
// stages remove the CORDIC gain from the horizontal length, CORDIC_STAGES
// more cells find the elevation, and an output register rounds and clamps.
// One request is taken every cycle while the chain is not frozen by a stalled
// receiver, set by the one-cell-per-step chain.
// The tolerance register is written through the APB port at address 0 and
// must only change while no request is in flight. Reset clears all valid
// bits and sets the tolerance to zero; no result is pending after reset.
// When the receiver stalls, the result waits in the output register; the
// chain keeps taking requests until a finished request reaches its last
// cell, and only then freezes as a whole until the output is taken.
`default_nettype none

module aim_azimuth_elevation #(
    parameter int COORD_BITS    = 32,
    parameter int CORDIC_STAGES = 16
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire [2:0]                   paddr,
    input  wire [31:0]                  pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  wire                         in_valid,
    output logic                        in_ready,
    input  wire signed [COORD_BITS-1:0] mount_x,
    input  wire signed [COORD_BITS-1:0] mount_y,
    input  wire signed [COORD_BITS-1:0] mount_z,
    input  wire signed [COORD_BITS-1:0] target_x,
    input  wire signed [COORD_BITS-1:0] target_y,
    input  wire signed [COORD_BITS-1:0] target_z,
    output logic                        out_valid,
    input  wire                         out_ready,
    output logic                        aim_valid,
    output logic signed [15:0]          azimuth,
    output logic [13:0]                 elevation
);
    import aae_pkg::*;

    // Datapath width: the difference, the guard bits and the CORDIC growth.
    localparam int W       = COORD_BITS + 12;
    localparam int N       = CORDIC_STAGES;
    localparam int AZ_SIDE = W + 1;
    localparam int EL_SIDE = ANG_W + 1;

    // Register index decoded from the word address.
    localparam logic REG_TOL = 1'b0;

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access phase.
    // ------------------------------------------------------------------
    tol_t tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= '0;
        else if (psel && penable && pwrite && (paddr[2] == REG_TOL))
            tol_reg <= pwdata[TOL_W-1:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TOL) ? {{(32 - TOL_W){1'b0}}, tol_reg} : '0;

    // ------------------------------------------------------------------
    // Chain enable. The whole chain moves together unless a finished
    // request sits in the last cell while the output register is still
    // held by the receiver.
    // ------------------------------------------------------------------
    logic en;
    logic last_valid;
    logic out_valid_reg;

    assign en       = !(out_valid_reg && !out_ready && last_valid);
    assign in_ready = en;

    // ------------------------------------------------------------------
    // Front: differences, tolerance test and half-turn pre-rotation.
    // ------------------------------------------------------------------
    logic                fr_valid, fr_aim;
    logic signed [W-1:0] fr_x, fr_y, fr_adz;
    angle_t              fr_z;

    aae_front #(
        .COORD_BITS (COORD_BITS),
        .W          (W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .tol       (tol_reg),
        .in_valid  (in_valid),
        .mount_x   (mount_x),
        .mount_y   (mount_y),
        .mount_z   (mount_z),
        .target_x  (target_x),
        .target_y  (target_y),
        .target_z  (target_z),
        .out_valid (fr_valid),
        .x_out     (fr_x),
        .y_out     (fr_y),
        .z_out     (fr_z),
        .adz_out   (fr_adz),
        .aim_out   (fr_aim)
    );

    // ------------------------------------------------------------------
    // Azimuth chain. The sideband carries the aim flag and |dz|.
    // ------------------------------------------------------------------
    logic                az_v    [0:N];
    logic signed [W-1:0] az_x    [0:N];
    logic signed [W-1:0] az_y    [0:N];
    angle_t              az_z    [0:N];
    logic [AZ_SIDE-1:0]  az_side [0:N];

    assign az_v[0]    = fr_valid;
    assign az_x[0]    = fr_x;
    assign az_y[0]    = fr_y;
    assign az_z[0]    = fr_z;
    assign az_side[0] = {fr_aim, fr_adz};

    for (genvar i = 0; i < N; i++)
    begin : g_az
        aae_cordic_cell #(
            .W      (W),
            .STAGE  (i),
            .SIDE_W (AZ_SIDE)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (az_v[i]),
            .x_in      (az_x[i]),
            .y_in      (az_y[i]),
            .z_in      (az_z[i]),
            .side_in   (az_side[i]),
            .out_valid (az_v[i+1]),
            .x_out     (az_x[i+1]),
            .y_out     (az_y[i+1]),
            .z_out     (az_z[i+1]),
            .side_out  (az_side[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Gain removal on the horizontal length. The residual y of the
    // azimuth chain is no longer needed.
    // ------------------------------------------------------------------
    logic                gn_valid;
    logic signed [W-1:0] gn_h, gn_adz;
    logic [EL_SIDE-1:0]  gn_side;

    aae_gain #(
        .W      (W),
        .SIDE_W (EL_SIDE)
    ) u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (az_v[N]),
        .x_in      (az_x[N]),
        .adz_in    (az_side[N][W-1:0]),
        .side_in   ({az_side[N][W], az_z[N]}),
        .out_valid (gn_valid),
        .h_out     (gn_h),
        .adz_out   (gn_adz),
        .side_out  (gn_side)
    );

    // ------------------------------------------------------------------
    // Elevation chain. The sideband carries the aim flag and the azimuth
    // accumulator.
    // ------------------------------------------------------------------
    logic                el_v    [0:N];
    logic signed [W-1:0] el_x    [0:N];
    logic signed [W-1:0] el_y    [0:N];
    angle_t              el_z    [0:N];
    logic [EL_SIDE-1:0]  el_side [0:N];

    assign el_v[0]    = gn_valid;
    assign el_x[0]    = gn_h;
    assign el_y[0]    = gn_adz;
    assign el_z[0]    = '0;
    assign el_side[0] = gn_side;

    for (genvar i = 0; i < N; i++)
    begin : g_el
        aae_cordic_cell #(
            .W      (W),
            .STAGE  (i),
            .SIDE_W (EL_SIDE)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (el_v[i]),
            .x_in      (el_x[i]),
            .y_in      (el_y[i]),
            .z_in      (el_z[i]),
            .side_in   (el_side[i]),
            .out_valid (el_v[i+1]),
            .x_out     (el_x[i+1]),
            .y_out     (el_y[i+1]),
            .z_out     (el_z[i+1]),
            .side_out  (el_side[i+1])
        );
    end

    assign last_valid = el_v[N];

    // ------------------------------------------------------------------
    // Output stage: round half up, clamp, and force zero angles for an
    // invalid target.
    // ------------------------------------------------------------------
    logic   fin_aim;
    angle_t az_acc, az_sum, el_sum;
    units_t az_units, el_units, az_clamped, el_clamped;

    logic                     aim_reg;
    logic signed [15:0]       az_reg, az_next;
    logic [13:0]              el_reg, el_next;

    assign fin_aim  = el_side[N][ANG_W];
    assign az_acc   = el_side[N][ANG_W-1:0];
    assign az_sum   = az_acc + ROUND_HALF;
    assign el_sum   = el_z[N] + ROUND_HALF;
    assign az_units = az_sum[ANG_W-1:ANG_FRAC];
    assign el_units = el_sum[ANG_W-1:ANG_FRAC];

    always_comb
    begin
        if (az_units < AZ_MIN)
            az_clamped = AZ_MIN;
        else if (az_units > AZ_MAX)
            az_clamped = AZ_MAX;
        else
            az_clamped = az_units;

        if (el_units < EL_MIN)
            el_clamped = EL_MIN;
        else if (el_units > EL_MAX)
            el_clamped = EL_MAX;
        else
            el_clamped = el_units;

        az_next = fin_aim ? az_clamped[15:0] : '0;
        el_next = fin_aim ? el_clamped[13:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en && last_valid)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en && last_valid)
        begin
            aim_reg <= fin_aim;
            az_reg  <= az_next;
            el_reg  <= el_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign aim_valid = aim_reg;
    assign azimuth   = az_reg;
    assign elevation = el_reg;

endmodule

`default_nettype wire
